### rtl/core/rflp_pkg.sv
// ---------------------------------------------------------------------------
// rflp_pkg
// Shared types and character codes for the reply frame length parser.
// ---------------------------------------------------------------------------
`default_nettype none

package rflp_pkg;

  // Default configuration
  localparam int DEF_MAX_DEPTH  = 8;
  localparam int DEF_COUNT_BITS = 32;

  // Character codes
  localparam logic [7:0] CHR_CR     = 8'h0D;
  localparam logic [7:0] CHR_LF     = 8'h0A;
  localparam logic [7:0] CHR_DOLLAR = 8'h24;
  localparam logic [7:0] CHR_PLUS   = 8'h2B;
  localparam logic [7:0] CHR_MINUS  = 8'h2D;
  localparam logic [7:0] CHR_COLON  = 8'h3A;
  localparam logic [7:0] CHR_STAR   = 8'h2A;
  localparam logic [7:0] CHR_ZERO   = 8'h30;
  localparam logic [7:0] CHR_NINE   = 8'h39;

  // Parser phase
  typedef enum logic [1:0] {
    PH_TYPE    = 2'd0,
    PH_LINE    = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_TRAILER = 2'd3
  } phase_t;

  // Kind of the element being parsed
  typedef enum logic [1:0] {
    KIND_SIMPLE = 2'd0,
    KIND_BULK   = 2'd1,
    KIND_ARRAY  = 2'd2
  } kind_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_BUSY    = 2'd0,
    ST_DONE    = 2'd1,
    ST_BADTYPE = 2'd2,
    ST_DEEP    = 2'd3
  } status_t;

  // Commands from the decoder to the array count stack
  typedef struct packed {
    logic push;    // open a new array
    logic finish;  // count down open arrays after a finished element
    logic clear;   // drop everything
  } stk_cmd_t;

  // Stack status back to the decoder
  typedef struct packed {
    logic full;     // no room for another array
    logic all_one;  // a finished element would close every open array
  } stk_stat_t;

endpackage

`default_nettype wire

### rtl/core/resp_frame_length_parser_core.sv
// ---------------------------------------------------------------------------
// resp_frame_length_parser_core
// Reply stream framer: reports where each complete reply frame ends.
// ---------------------------------------------------------------------------
// Input channel: in_valid / in_stall with one received byte, in_rx_byte.
// Result channel: out_valid / out_stall, one word per input byte carrying
//   out_status (0 in progress, 1 frame complete, 2 bad type byte,
//   3 nesting too deep) and out_frame_length (nonzero only on complete).
// Throughput: one byte per cycle while out_stall stays low. Every byte is fully handled
//   by the decoder between the input register and the result register.
// Path: an accepted byte waits in the input register and is decoded into the
//   result register once that register is empty or not held by out_stall.
// Reset (rst_n low, synchronous) empties both registers and returns the
//   parser to waiting for a type byte with no open arrays.
// When the receiver stalls, the result word holds; one more byte is taken
//   into the input register and in_stall rises after that.
// After a bad type byte or a too deep array the parser starts over.
// ---------------------------------------------------------------------------
`default_nettype none

module resp_frame_length_parser_core
  import rflp_pkg::*;
#(
  parameter int MAX_DEPTH  = DEF_MAX_DEPTH,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic [31:0]      out_frame_length
);

  logic                  s1_valid_r;
  logic [7:0]            s1_byte_r;
  logic                  out_valid_r;
  logic [1:0]            status_r;
  logic [31:0]           length_r;

  logic                  advance;
  logic                  step;
  stk_cmd_t              stk_cmd;
  stk_stat_t             stk_stat;
  logic [COUNT_BITS-1:0] push_count;
  logic [1:0]            status;
  logic [31:0]           frame_length;

  assign advance  = !out_valid_r || !out_stall;
  assign step     = s1_valid_r && advance;
  assign in_stall = s1_valid_r && !advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  rflp_decode #(
    .COUNT_BITS (COUNT_BITS)
  ) u_decode (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .rx_byte      (s1_byte_r),
    .stk_stat     (stk_stat),
    .stk_cmd      (stk_cmd),
    .push_count   (push_count),
    .status       (status),
    .frame_length (frame_length)
  );

  rflp_stack #(
    .MAX_DEPTH  (MAX_DEPTH),
    .COUNT_BITS (COUNT_BITS)
  ) u_stack (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .cmd        (stk_cmd),
    .push_count (push_count),
    .stat       (stk_stat)
  );

  // Result register; hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      status_r <= status;
      length_r <= frame_length;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_frame_length = length_r;

  // Checks
  a_len_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r != ST_DONE) |-> length_r == 32'd0)
    else $error("frame length without completed frame");

  a_len_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r == ST_DONE) |-> length_r != 32'd0)
    else $error("completed frame with zero length");

  a_stall_holding: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r)
    else $error("input stalled with room to move");

endmodule

`default_nettype wire

### rtl/core/rflp_stack.sv
// ---------------------------------------------------------------------------
// rflp_stack
// Stack of open array element counts. A finished element pops every top
// entry whose count is one and decrements the first entry above one.
// ---------------------------------------------------------------------------
`default_nettype none

module rflp_stack
  import rflp_pkg::*;
#(
  parameter int MAX_DEPTH  = DEF_MAX_DEPTH,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  step,
  input  wire stk_cmd_t              cmd,
  input  wire logic [COUNT_BITS-1:0] push_count,
  output stk_stat_t                  stat
);

  localparam int DW = $clog2(MAX_DEPTH + 1);
  localparam int IW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  logic [COUNT_BITS-1:0] count_r [MAX_DEPTH];
  logic [MAX_DEPTH-1:0]  one_r;
  logic [DW-1:0]         depth_r;

  logic                  found;
  logic [IW-1:0]         sel;

  // Find the highest open entry whose count is above one
  always_comb begin
    found = 1'b0;
    sel   = '0;
    for (int i = 0; i < MAX_DEPTH; i++) begin
      if ((DW'(i) < depth_r) && !one_r[i]) begin
        found = 1'b1;
        sel   = IW'(i);
      end
    end
  end

  assign stat.full    = (depth_r >= DW'(MAX_DEPTH));
  assign stat.all_one = !found;

  // Track the stack depth
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
    end else if (step) begin
      if (cmd.clear) begin
        depth_r <= '0;
      end else if (cmd.push) begin
        depth_r <= depth_r + DW'(1);
      end else if (cmd.finish) begin
        depth_r <= found ? (DW'(sel) + DW'(1)) : '0;
      end
    end
  end

  // Load or count down each entry in place
  always_ff @(posedge clk) begin
    if (step && !cmd.clear) begin
      for (int g = 0; g < MAX_DEPTH; g++) begin
        if (cmd.push && (depth_r == DW'(g))) begin
          count_r[g] <= push_count;
          one_r[g]   <= (push_count == COUNT_BITS'(1));
        end else if (cmd.finish && found && (sel == IW'(g))) begin
          count_r[g] <= count_r[g] - COUNT_BITS'(1);
          one_r[g]   <= (count_r[g] == COUNT_BITS'(2));
        end
      end
    end
  end

  // Checks
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DW'(MAX_DEPTH))
    else $error("stack depth beyond limit");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    step && cmd.push && !cmd.clear |-> !stat.full)
    else $error("push into full stack");

  a_push_finish: assert property (@(posedge clk) disable iff (!rst_n)
    step && cmd.push |-> !cmd.finish)
    else $error("push and finish in one step");

endmodule

`default_nettype wire

### rtl/core/rflp_decode.sv
// ---------------------------------------------------------------------------
// rflp_decode
// Per-byte parse state: type byte, header line, bulk payload and trailer.
// Produces the status and frame length of each byte and drives the stack.
// ---------------------------------------------------------------------------
`default_nettype none

module rflp_decode
  import rflp_pkg::*;
#(
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  step,
  input  wire logic [7:0]            rx_byte,
  input  wire stk_stat_t             stk_stat,
  output stk_cmd_t                   stk_cmd,
  output logic [COUNT_BITS-1:0]      push_count,
  output logic [1:0]                 status,
  output logic [31:0]                frame_length
);

  localparam int AW = COUNT_BITS + 4;

  phase_t                phase_r, phase_nxt;
  kind_t                 kind_r, kind_nxt;
  logic [COUNT_BITS-1:0] hv_r, hv_nxt;
  logic                  neg_r, neg_nxt;
  logic                  saw_cr_r, saw_cr_nxt;
  logic [COUNT_BITS-1:0] pl_r, pl_nxt;
  logic [31:0]           bc_r, bc_nxt;

  logic [COUNT_BITS-1:0] pl_dec;
  logic [AW-1:0]         acc;
  logic                  is_digit;
  logic                  done, bad, deep, push;
  logic                  complete;

  assign pl_dec   = (pl_r != '0) ? (pl_r - COUNT_BITS'(1)) : pl_r;
  assign is_digit = (rx_byte >= CHR_ZERO) && (rx_byte <= CHR_NINE);
  // Decimal accumulate: value * 10 + digit
  assign acc      = ({4'b0, hv_r} << 3) + ({4'b0, hv_r} << 1) + AW'(rx_byte[3:0]);
  assign push_count = hv_r;

  // Next state
  always_comb begin
    phase_nxt  = phase_r;
    kind_nxt   = kind_r;
    hv_nxt     = hv_r;
    neg_nxt    = neg_r;
    saw_cr_nxt = saw_cr_r;
    pl_nxt     = pl_r;
    bc_nxt     = (bc_r != '1) ? (bc_r + 32'd1) : bc_r;
    done       = 1'b0;
    bad        = 1'b0;
    deep       = 1'b0;
    push       = 1'b0;
    unique case (phase_r)
      PH_TYPE: begin
        hv_nxt     = '0;
        neg_nxt    = 1'b0;
        saw_cr_nxt = 1'b0;
        priority if (rx_byte == CHR_PLUS || rx_byte == CHR_MINUS ||
                     rx_byte == CHR_COLON) begin
          kind_nxt  = KIND_SIMPLE;
          phase_nxt = PH_LINE;
        end else if (rx_byte == CHR_DOLLAR) begin
          kind_nxt  = KIND_BULK;
          phase_nxt = PH_LINE;
        end else if (rx_byte == CHR_STAR) begin
          kind_nxt  = KIND_ARRAY;
          phase_nxt = PH_LINE;
        end else begin
          bad = 1'b1;
        end
      end
      PH_LINE: begin
        if (saw_cr_r && (rx_byte == CHR_LF)) begin
          saw_cr_nxt = 1'b0;
          unique case (kind_r)
            KIND_BULK: begin
              priority if (neg_r) begin
                done = 1'b1;
              end else if (hv_r == '0) begin
                phase_nxt = PH_TRAILER;
                pl_nxt    = COUNT_BITS'(2);
              end else begin
                phase_nxt = PH_PAYLOAD;
                pl_nxt    = hv_r;
              end
            end
            KIND_ARRAY: begin
              priority if (neg_r || (hv_r == '0)) begin
                done = 1'b1;
              end else if (stk_stat.full) begin
                deep = 1'b1;
              end else begin
                push      = 1'b1;
                phase_nxt = PH_TYPE;
              end
            end
            default: begin
              done = 1'b1;
            end
          endcase
        end else begin
          // Header digits and sign; simple lines are skipped
          if (kind_r != KIND_SIMPLE) begin
            if (is_digit) begin
              hv_nxt = (acc[AW-1:COUNT_BITS] != '0) ? '1 : acc[COUNT_BITS-1:0];
            end else if (rx_byte == CHR_MINUS) begin
              neg_nxt = 1'b1;
            end
          end
          saw_cr_nxt = (rx_byte == CHR_CR);
        end
      end
      PH_PAYLOAD: begin
        if (pl_dec == '0) begin
          phase_nxt = PH_TRAILER;
          pl_nxt    = COUNT_BITS'(2);
        end else begin
          pl_nxt = pl_dec;
        end
      end
      PH_TRAILER: begin
        pl_nxt = pl_dec;
        if (pl_dec == '0) begin
          done = 1'b1;
        end
      end
    endcase
    if (done) begin
      phase_nxt = PH_TYPE;
    end
  end

  // Outputs and stack commands
  always_comb begin
    complete       = done && stk_stat.all_one;
    stk_cmd.push   = push;
    stk_cmd.finish = done && !complete;
    stk_cmd.clear  = bad || deep || complete;
    frame_length   = complete ? bc_nxt : 32'd0;
    priority if (bad) begin
      status = ST_BADTYPE;
    end else if (deep) begin
      status = ST_DEEP;
    end else if (complete) begin
      status = ST_DONE;
    end else begin
      status = ST_BUSY;
    end
  end

  // Update state on each processed byte; start over after a frame or error
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_TYPE;
      kind_r   <= KIND_SIMPLE;
      hv_r     <= '0;
      neg_r    <= 1'b0;
      saw_cr_r <= 1'b0;
      pl_r     <= '0;
      bc_r     <= '0;
    end else if (step) begin
      if (stk_cmd.clear) begin
        phase_r  <= PH_TYPE;
        kind_r   <= KIND_SIMPLE;
        hv_r     <= '0;
        neg_r    <= 1'b0;
        saw_cr_r <= 1'b0;
        pl_r     <= '0;
        bc_r     <= '0;
      end else begin
        phase_r  <= phase_nxt;
        kind_r   <= kind_nxt;
        hv_r     <= hv_nxt;
        neg_r    <= neg_nxt;
        saw_cr_r <= saw_cr_nxt;
        pl_r     <= pl_nxt;
        bc_r     <= bc_nxt;
      end
    end
  end

  // Checks
  a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> pl_r != '0)
    else $error("payload phase with nothing left");

  a_trailer_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_TRAILER |-> (pl_r == COUNT_BITS'(1) || pl_r == COUNT_BITS'(2)))
    else $error("trailer count out of range");

  a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({bad, deep, push, done}) <= 1)
    else $error("conflicting parse events");

endmodule

`default_nettype wire

### tb/tb_resp_frame_length_parser_core.sv
// ---------------------------------------------------------------------------
// tb_resp_frame_length_parser_core
// Self-checking bench for the reply stream framer. Directed byte streams
// hit line endings, bulk and array headers, null and empty elements, bad
// type bytes, over-deep nesting and header saturation. Random frames with
// noise and cut-off tails follow. A local frame parser predicts the status
// and frame length word for every accepted byte.
// ---------------------------------------------------------------------------
module tb_resp_frame_length_parser_core;
  timeunit 1ns;
  timeprecision 1ps;

  import rflp_pkg::*;

  localparam int STACK_DEPTH = DEF_MAX_DEPTH;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    status_t     st;
    logic [31:0] len;
  } result_word_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [31:0] out_frame_length;

  // Parser shadow state
  phase_t      fr_phase;
  kind_t       fr_kind;
  logic [31:0] fr_stack [STACK_DEPTH];
  int          fr_depth;
  logic [31:0] fr_hdr_val;
  logic        fr_hdr_neg;
  logic        fr_saw_cr;
  logic [31:0] fr_left;
  logic [31:0] fr_count;

  result_word_t expected_words[$];
  logic [7:0]   frame_bytes[$];
  int           error_count = 0;
  int           bytes_sent = 0;

  // Sender pacing
  int tx_gap_max = 0;
  int burst_left = 0;

  // Receiver pacing
  logic [1:0] rx_mode = 2'd0;
  int         hold_ticket = 0;
  int         hold_served = 0;
  int         hold_left = 0;
  int         run_left = 0;
  logic       run_stall = 1'b0;

  resp_frame_length_parser_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_frame_length (out_frame_length)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(5_000_000);
    $display("tb_resp_frame_length_parser_core: done, errors");
    $finish;
  end

  // Return the shadow parser to its reset state
  task automatic frame_clear();
    fr_phase   = PH_TYPE;
    fr_kind    = KIND_SIMPLE;
    for (int i = 0; i < STACK_DEPTH; i++) fr_stack[i] = '0;
    fr_depth   = 0;
    fr_hdr_val = '0;
    fr_hdr_neg = 1'b0;
    fr_saw_cr  = 1'b0;
    fr_left    = '0;
    fr_count   = '0;
  endtask

  // Advance the shadow parser by one byte and form the expected word
  task automatic parse_rx_byte(input logic [7:0] b, output result_word_t w);
    logic        done;
    logic        closed;
    logic        going;
    logic [31:0] top;
    logic [63:0] acc;
    status_t     st;
    done = 1'b0;
    st   = ST_BUSY;
    if (fr_count != 32'hFFFF_FFFF) fr_count = fr_count + 1;

    case (fr_phase)
      PH_TYPE: begin
        fr_hdr_val = '0;
        fr_hdr_neg = 1'b0;
        fr_saw_cr  = 1'b0;
        if (b == CHR_PLUS || b == CHR_MINUS || b == CHR_COLON) begin
          fr_kind  = KIND_SIMPLE;
          fr_phase = PH_LINE;
        end else if (b == CHR_DOLLAR) begin
          fr_kind  = KIND_BULK;
          fr_phase = PH_LINE;
        end else if (b == CHR_STAR) begin
          fr_kind  = KIND_ARRAY;
          fr_phase = PH_LINE;
        end else begin
          st = ST_BADTYPE;
        end
      end
      PH_LINE: begin
        if (fr_saw_cr && b == CHR_LF) begin
          fr_saw_cr = 1'b0;
          if (fr_kind == KIND_BULK) begin
            if (fr_hdr_neg) begin
              done = 1'b1;
            end else if (fr_hdr_val == 0) begin
              fr_phase = PH_TRAILER;
              fr_left  = 32'd2;
            end else begin
              fr_phase = PH_PAYLOAD;
              fr_left  = fr_hdr_val;
            end
          end else if (fr_kind == KIND_ARRAY) begin
            if (fr_hdr_neg || fr_hdr_val == 0) begin
              done = 1'b1;
            end else if (fr_depth >= STACK_DEPTH) begin
              st = ST_DEEP;
            end else begin
              fr_stack[fr_depth] = fr_hdr_val;
              fr_depth = fr_depth + 1;
              fr_phase = PH_TYPE;
            end
          end else begin
            done = 1'b1;
          end
        end else begin
          // Accumulate header digits; a minus anywhere marks it negative
          if (fr_kind != KIND_SIMPLE) begin
            if (b >= CHR_ZERO && b <= CHR_NINE) begin
              acc = {32'd0, fr_hdr_val} * 64'd10 + {56'd0, b - CHR_ZERO};
              if (acc > 64'h0000_0000_FFFF_FFFF) acc = 64'h0000_0000_FFFF_FFFF;
              fr_hdr_val = acc[31:0];
            end else if (b == CHR_MINUS) begin
              fr_hdr_neg = 1'b1;
            end
          end
          fr_saw_cr = (b == CHR_CR);
        end
      end
      PH_PAYLOAD: begin
        if (fr_left > 0) fr_left = fr_left - 1;
        if (fr_left == 0) begin
          fr_phase = PH_TRAILER;
          fr_left  = 32'd2;
        end
      end
      default: begin
        if (fr_left > 0) fr_left = fr_left - 1;
        if (fr_left == 0) done = 1'b1;
      end
    endcase

    w.st  = ST_BUSY;
    w.len = '0;
    if (st == ST_BADTYPE || st == ST_DEEP) begin
      frame_clear();
      w.st = st;
    end else if (done) begin
      // Count down open arrays; one element may close several
      fr_phase = PH_TYPE;
      closed = 1'b1;
      going  = 1'b1;
      while (going && fr_depth > 0) begin
        top = fr_stack[fr_depth - 1];
        if (top > 0) top = top - 1;
        if (top != 0) begin
          fr_stack[fr_depth - 1] = top;
          closed = 1'b0;
          going  = 1'b0;
        end else begin
          fr_depth = fr_depth - 1;
        end
      end
      if (closed) begin
        w.st  = ST_DONE;
        w.len = fr_count;
        frame_clear();
      end
    end
  endtask

  // Offer one byte, wait for the handshake, predict, then pace the sender
  task automatic push_rx_byte(input logic [7:0] b);
    result_word_t w;
    int gap;
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    parse_rx_byte(b, w);
    expected_words.push_back(w);
    bytes_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (tx_gap_max > 0) begin
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  endtask

  task automatic put_byte(input logic [7:0] b);
    frame_bytes.push_back(b);
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) frame_bytes.push_back(s[i]);
  endtask

  task automatic put_line(input string s);
    put_text(s);
    frame_bytes.push_back(CHR_CR);
    frame_bytes.push_back(CHR_LF);
  endtask

  task automatic flush_bytes();
    logic [7:0] b;
    while (frame_bytes.size() != 0) begin
      b = frame_bytes[0];
      frame_bytes.delete(0);
      push_rx_byte(b);
    end
  endtask

  // Check each result word and run the receiver's stall pattern
  always @(posedge clk) begin
    result_word_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word: status %0d length %0d", $time, out_status,
                 out_frame_length);
        error_count++;
      end else begin
        w = expected_words[0];
        expected_words.delete(0);
        if (out_status !== w.st) begin
          $display("%0t: status mismatch: expected %0d actual %0d", $time, w.st,
                   out_status);
          error_count++;
        end
        if (out_frame_length !== w.len) begin
          $display("%0t: frame_length mismatch: expected %0d actual %0d", $time, w.len,
                   out_frame_length);
          error_count++;
        end
      end
    end

    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_served != hold_ticket) begin
      hold_served = hold_ticket;
      hold_left   = HOLD_CYCLES - 1;
      out_stall  <= 1'b1;
    end else if (rx_mode == 2'd0) begin
      out_stall <= 1'b0;
    end else begin
      if (run_left == 0) begin
        run_stall = ($urandom_range(0, 9) < 4);
        run_left  = run_stall ? $urandom_range(1, 6) : $urandom_range(1, 10);
      end
      run_left--;
      out_stall <= run_stall;
    end
  end

  // Simple, error and integer lines; lone CR and extreme byte values
  task automatic test_simple_lines();
    put_line("+OK");
    put_line("-ERR bad");
    put_line(":0");
    put_line(":-255");
    put_text("+a");
    put_byte(CHR_CR);
    put_line("b");
    put_text("+");
    put_byte(CHR_CR);
    put_line("");
    put_text("+");
    put_byte(8'h00);
    put_byte(8'hFF);
    put_line("");
    flush_bytes();
  endtask

  // Bad type bytes at top level and inside an open array
  task automatic test_bad_type();
    put_byte(8'h00);
    put_byte(8'hFF);
    put_byte(CHR_CR);
    put_text("A");
    put_line("*2");
    put_line("+a");
    put_byte(8'hFF);
    put_line(":7");
    flush_bytes();
  endtask

  // Bulk strings: plain, empty, null, ignored header characters
  task automatic test_bulk();
    put_line("$3");
    put_line("abc");
    put_line("$0");
    put_text("xy");
    put_line("$-1");
    put_line("$-0");
    put_line("$1x2");
    put_text("abcdefghijkl");
    put_text("zz");
    put_line("$2");
    put_line("");
    put_line("");
    flush_bytes();
  endtask

  // Arrays: empty, null, nested closes, saturating count
  task automatic test_arrays();
    put_line("*0");
    put_line("*-1");
    put_line("*1-");
    put_line("*2");
    put_line(":1");
    put_line("$-1");
    put_line("*1");
    put_line("*1");
    put_line("*1");
    put_line("+x");
    put_line("*2");
    put_line("*0");
    put_line("*1");
    put_line("+y");
    put_line("*99999999999");
    put_line("+a");
    put_text("!");
    flush_bytes();
  endtask

  // Nesting at the stack limit, then one level past it
  task automatic test_too_deep();
    for (int i = 0; i < STACK_DEPTH; i++) put_line("*1");
    put_line("+x");
    for (int i = 0; i <= STACK_DEPTH; i++) put_line("*1");
    put_line("+ok");
    flush_bytes();
  endtask

  // One leaf element with random content
  task automatic put_leaf();
    int n;
    int r;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        case ($urandom_range(0, 2))
          0: put_byte(CHR_PLUS);
          1: put_byte(CHR_MINUS);
          default: put_byte(CHR_COLON);
        endcase
        n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++) begin
          r = $urandom_range(0, 9);
          if (r == 0) put_byte(CHR_CR);
          else if (r == 1) put_byte(8'($urandom_range(0, 255)));
          else put_byte(8'($urandom_range(32, 126)));
        end
        put_line("");
      end
      4, 5, 6: begin
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
        put_byte(CHR_DOLLAR);
        if ($urandom_range(0, 7) == 0) put_text(" ");
        put_line($sformatf("%0d", n));
        for (int i = 0; i < n; i++) put_byte(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 3) == 0) begin
          put_byte(8'($urandom_range(0, 255)));
          put_byte(8'($urandom_range(0, 255)));
        end else begin
          put_line("");
        end
      end
      7: put_line("$-1");
      8: begin
        r = $urandom_range(0, 2000);
        put_line($sformatf(":%0d", r - 1000));
      end
      default: begin
        if ($urandom_range(0, 1) == 0) put_line("*0");
        else put_line("*-1");
      end
    endcase
  endtask

  // Build one frame; always nest until force_depth, then nest at random
  task automatic put_frame(input int force_depth, input int max_nest);
    int   depth;
    int   n;
    int   cnt [10];
    logic closing;
    depth = 0;
    do begin
      if (depth < force_depth || (depth < max_nest && $urandom_range(0, 2) == 0)) begin
        n = (force_depth > 0) ? $urandom_range(1, 2) : $urandom_range(1, 3);
        put_line($sformatf("*%0d", n));
        cnt[depth] = n;
        depth++;
      end else begin
        put_leaf();
        closing = 1'b1;
        while (closing && depth > 0) begin
          cnt[depth - 1]--;
          if (cnt[depth - 1] != 0) closing = 1'b0;
          else depth--;
        end
      end
    end while (depth > 0);
  endtask

  // Mostly well-formed frames, some deep, some noise and cut-off frames
  task automatic test_random_frames(input int n_bytes);
    int stop_at;
    int r;
    int cut;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        put_frame(0, 3);
      end else if (r < 83) begin
        put_frame($urandom_range(STACK_DEPTH - 1, STACK_DEPTH + 1), STACK_DEPTH + 1);
      end else if (r < 91) begin
        cut = $urandom_range(1, 5);
        for (int i = 0; i < cut; i++) put_byte(8'($urandom_range(0, 255)));
      end else begin
        put_frame(0, 3);
        cut = $urandom_range(1, frame_bytes.size());
        while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
      end
      flush_bytes();
    end
  endtask

  // Hold the receiver off while the sender keeps offering back to back
  task automatic test_backpressure();
    tx_gap_max = 0;
    hold_ticket <= hold_ticket + 1;
    for (int i = 0; i < 6; i++) put_line("+fill");
    put_line("$4");
    put_line("data");
    flush_bytes();
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_rx_byte = 8'h00;
    frame_clear();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    tx_gap_max = 3;
    rx_mode   <= 2'd1;
    test_simple_lines();
    test_bad_type();
    test_bulk();
    test_arrays();
    test_too_deep();
    test_backpressure();

    // Random traffic under several pacing settings
    tx_gap_max = 0;
    rx_mode   <= 2'd0;
    test_random_frames(370);
    tx_gap_max = 4;
    rx_mode   <= 2'd1;
    test_random_frames(370);
    test_backpressure();
    tx_gap_max = 8;
    rx_mode   <= 2'd0;
    test_random_frames(370);
    tx_gap_max = 0;
    rx_mode   <= 2'd1;
    test_random_frames(370);

    // Drain and let the pipeline settle
    in_valid <= 1'b0;
    rx_mode  <= 2'd0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_resp_frame_length_parser_core: done, clean");
    end else begin
      $display("tb_resp_frame_length_parser_core: done, errors");
    end
    $finish;
  end

endmodule
